// ===== rtl/etsc_pkg.sv =====
// ----------------------------------------------------------------------------
// etsc_pkg
// Shared types, codes and constants of the edge trigger sample capture block.
// ----------------------------------------------------------------------------
package etsc_pkg;

	localparam int BUFFER_DEPTH = 1024;

	localparam int SAMPLE_W = 12;
	localparam int KIND_W   = 2;
	localparam int MODE_W   = 2;
	localparam int COUNT_W  = 11;
	localparam int INDEX_W  = 10;
	localparam int PHASE_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ARM     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERRUN = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

	// trigger modes
	localparam logic [MODE_W-1:0] MODE_TOGGLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FALLING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RISING  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FREE    = 2'd3;

	// run phases
	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ARMED   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_CAPTURE = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DONE    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ERROR   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

	// reset values
	localparam logic [SAMPLE_W-1:0] LEVEL_RST = 12'h7ff;
	localparam logic [MODE_W-1:0]   MODE_RST  = MODE_TOGGLE;
	localparam logic [COUNT_W-1:0]  COUNT_RST = 11'd992;

	localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(BUFFER_DEPTH);

	typedef struct packed {
		logic [SAMPLE_W-1:0] level;
		logic [MODE_W-1:0]   mode;
		logic [COUNT_W-1:0]  count;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SAMPLE_W-1:0] sample_value;
	} item_t;

	typedef struct packed {
		logic                captured;
		logic [SAMPLE_W-1:0] captured_value;
		logic [INDEX_W-1:0]  capture_index;
		logic                frame_last;
		logic [PHASE_W-1:0]  run_status;
	} result_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               first_seen;
		logic               watch_above;
		logic               need_ref;
		logic [COUNT_W-1:0] count;
	} state_t;

	// effective frame length: zero acts as one, clipped to the buffer
	function automatic logic [COUNT_W-1:0] frame_length(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] len;
		len = n;
		if (len == '0)
			len = COUNT_W'(1);
		if (len > DEPTH_CNT)
			len = DEPTH_CNT;
		return len;
	endfunction

endpackage

// ===== rtl/etsc_item_if.sv =====
// ----------------------------------------------------------------------------
// etsc_item_if
// Input channel: sample, arm and overrun items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface etsc_item_if;
	import etsc_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output kind, output sample_value, input ready);
	modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

// ===== rtl/etsc_result_if.sv =====
// ----------------------------------------------------------------------------
// etsc_result_if
// Output channel: one capture result per input item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface etsc_result_if;
	import etsc_pkg::*;

	logic                valid;
	logic                ready;
	logic                captured;
	logic [SAMPLE_W-1:0] captured_value;
	logic [INDEX_W-1:0]  capture_index;
	logic                frame_last;
	logic [PHASE_W-1:0]  run_status;

	modport source (output valid, output captured, output captured_value,
		output capture_index, output frame_last, output run_status, input ready);
	modport sink   (input valid, input captured, input captured_value,
		input capture_index, input frame_last, input run_status, output ready);
endinterface

// ===== rtl/etsc_step.sv =====
// ----------------------------------------------------------------------------
// etsc_step
// Trigger detection and capture bookkeeping for one item: next state and result.
// ----------------------------------------------------------------------------
module etsc_step (
	input  etsc_pkg::cfg_t    cfg,
	input  etsc_pkg::state_t  st,
	input  etsc_pkg::item_t   it,
	output etsc_pkg::state_t  st_next,
	output etsc_pkg::result_t res
);
	import etsc_pkg::*;

	logic               below;
	logic               above;
	logic               fire;
	logic               store;
	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] len;

	assign below     = it.sample_value < cfg.level;
	assign above     = it.sample_value > cfg.level;
	assign count_inc = st.count + COUNT_W'(1);
	assign len       = frame_length(cfg.count);

	always_comb begin
		st_next = st;
		fire    = 1'b0;
		store   = 1'b0;
		res     = '0;

		unique case (it.kind)
			KIND_ARM: begin
				st_next.first_seen  = 1'b0;
				st_next.watch_above = 1'b0;
				st_next.need_ref    = 1'b1;
				st_next.count       = '0;
				st_next.phase       = (cfg.mode == MODE_FREE) ? PH_CAPTURE : PH_ARMED;
			end
			KIND_OVERRUN: begin
				st_next.phase = PH_ERROR;
			end
			KIND_SAMPLE: begin
				if (st.phase == PH_ARMED) begin
					unique case (cfg.mode)
						MODE_TOGGLE: begin
							if (st.need_ref) begin
								st_next.watch_above = below;
								st_next.need_ref    = 1'b0;
								st_next.first_seen  = 1'b1;
							end else begin
								fire = st.watch_above ? above : below;
							end
						end
						MODE_FALLING: begin
							if (!st.first_seen) begin
								if (above)
									st_next.first_seen = 1'b1;
							end else begin
								fire = below;
							end
						end
						MODE_RISING: begin
							if (!st.first_seen) begin
								if (below)
									st_next.first_seen = 1'b1;
							end else begin
								fire = above;
							end
						end
						default: begin
							fire = 1'b1;
						end
					endcase
					if (fire) begin
						st_next.phase = PH_CAPTURE;
						store         = (cfg.mode == MODE_FREE);
					end
				end else if (st.phase == PH_CAPTURE) begin
					store = 1'b1;
				end
				if (store) begin
					res.captured       = 1'b1;
					res.captured_value = it.sample_value;
					res.capture_index  = st.count[INDEX_W-1:0];
					if (count_inc >= len) begin
						res.frame_last = 1'b1;
						st_next.phase  = PH_DONE;
					end
					st_next.count = count_inc;
				end
			end
			default: begin
			end
		endcase

		res.run_status = st_next.phase;
	end

endmodule

// ===== rtl/edge_trigger_sample_capture.sv =====
// ----------------------------------------------------------------------------
// edge_trigger_sample_capture
// Scope-style edge trigger and frame capture for 12-bit converter samples.
//
// Channels: item (sink) takes sample, arm and overrun items; result (source)
// returns exactly one result per item: capture flag, value, index within the
// frame, last mark and the run phase after the item. Both use valid/ready;
// an item moves when valid and ready are high at a rising clock edge.
// Configuration: cfg_we/cfg_index/cfg_data write trigger_level (0),
// trigger_mode (1) and sample_count (2); the user must write them only
// while the block is idle, which the block itself does not enforce.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless result.ready stalls; the trigger
// compare and count update sit in a single stage between the two registers.
// Reset: phase idle, configuration at its reset values, both channels empty.
// Stall: when the receiver holds ready low the result register holds; one
// more item is taken if the input register is empty, then item.ready drops.
// ----------------------------------------------------------------------------
module edge_trigger_sample_capture (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [etsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [etsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	etsc_item_if.sink                          item,
	etsc_result_if.source                      result
);
	import etsc_pkg::*;

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	item_t   item_in;

	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign item_in    = '{kind: item.kind, sample_value: item.sample_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level <= LEVEL_RST;
			cfg_q.mode  <= MODE_RST;
			cfg_q.count <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL: cfg_q.level <= cfg_data[SAMPLE_W-1:0];
				REG_MODE:  cfg_q.mode  <= cfg_data[MODE_W-1:0];
				REG_COUNT: cfg_q.count <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '{phase: PH_IDLE, first_seen: 1'b0, watch_above: 1'b0,
				need_ref: 1'b0, count: '0};
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1)
					st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			item_s1 <= item_in;
		if (advance && valid_s1)
			res_q <= res_next;
	end

	etsc_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.it      (item_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	assign result.valid          = out_valid_q;
	assign result.captured       = res_q.captured;
	assign result.captured_value = res_q.captured_value;
	assign result.capture_index  = res_q.capture_index;
	assign result.frame_last     = res_q.frame_last;
	assign result.run_status     = res_q.run_status;

	a_last_is_captured: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_last |-> res_q.captured && res_q.run_status == PH_DONE)
		else $error("frame_last without a stored sample ending the frame");

	a_capture_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.captured |->
			res_q.run_status == PH_CAPTURE || res_q.run_status == PH_DONE)
		else $error("sample stored outside capture");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count <= DEPTH_CNT)
		else $error("capture count beyond buffer depth");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(st_q) && $stable(res_q))
		else $error("state moved while the result was stalled");

	a_arm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && item_s1.kind == KIND_ARM |=>
			st_q.count == '0 && (st_q.phase == PH_ARMED || st_q.phase == PH_CAPTURE))
		else $error("arm did not restart the frame");

endmodule
